FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers shared by the checker modules
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: design/mrba_pkg.sv
// ----------------------------------------------------------------------------
// mrba_pkg
// shared types and constants of the multi-region bump allocator
// ----------------------------------------------------------------------------
package mrba_pkg;

   // regions in use, 1 to 4
   localparam int REGIONS     = 4;
   // storage for region registers is always four regions deep
   localparam int MAX_REGIONS = 4;
   // allocation alignment in bytes, a power of two from 1 to 256
   localparam int ALIGN_BYTES = 4;

   localparam int ADDR_W   = 16;
   localparam int CURSOR_W = 17;
   localparam int LEFT_W   = 17;
   localparam int RIDX_W   = 2;
   localparam int CSR_IDX_W = 3;
   localparam int IDX_W     = (REGIONS > 1) ? $clog2(REGIONS) : 1;
   localparam int MAX_IDX_W = $clog2(MAX_REGIONS);

   // command codes
   localparam logic CMD_RESTART = 1'b0;
   localparam logic CMD_RESERVE = 1'b1;

   // low bit of a register index selects first or last address
   localparam logic CSR_SEL_FIRST = 1'b0;
   localparam logic CSR_SEL_LAST  = 1'b1;

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } state_type;

   // result of checking one region against the request
   typedef struct packed {
      logic                fits;
      logic [ADDR_W-1:0]   start;
      logic [LEFT_W-1:0]   left;
      logic [CURSOR_W-1:0] next_cursor;
   } fit_type;

endpackage

FILE: design/mrba_fit_unit.sv
// ----------------------------------------------------------------------------
// mrba_fit_unit
// aligns one region cursor and tests whether the request fits in that region
// ----------------------------------------------------------------------------
module mrba_fit_unit (
   input  logic [mrba_pkg::CURSOR_W-1:0] cursor,
   input  logic [mrba_pkg::ADDR_W-1:0]   last_addr,
   input  logic [mrba_pkg::ADDR_W-1:0]   size,
   output mrba_pkg::fit_type             result
);
   import mrba_pkg::*;

   // one extra bit so rounding up a large cursor never wraps
   localparam int ALN_W = CURSOR_W + 1;
   localparam logic [ALN_W-1:0] ALIGN_ADD  = ALN_W'(ALIGN_BYTES - 1);
   localparam logic [ALN_W-1:0] ALIGN_MASK = ~ALN_W'(ALIGN_BYTES - 1);

   logic [ALN_W-1:0]    aligned;
   logic                in_range;
   logic [LEFT_W-1:0]   span;

   always_comb begin
      aligned  = ({1'b0, cursor} + ALIGN_ADD) & ALIGN_MASK;
      in_range = aligned <= {{(ALN_W - ADDR_W){1'b0}}, last_addr};
      // only meaningful when in range, then aligned fits in ADDR_W bits
      span     = {1'b0, last_addr} - LEFT_W'(aligned[ADDR_W-1:0]) + LEFT_W'(1);

      result.fits        = in_range && (span >= {1'b0, size});
      result.start       = aligned[ADDR_W-1:0];
      result.left        = span - {1'b0, size};
      result.next_cursor = {1'b0, aligned[ADDR_W-1:0]} + {1'b0, size};
   end

endmodule

FILE: design/multi_region_bump_allocator.sv
// ----------------------------------------------------------------------------
// multi_region_bump_allocator
// first-fit bump allocator over up to four address regions
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake               payload
//   req       in         req_valid / req_ready   command, request_bytes
//   rsp       out        rsp_valid / rsp_ready   granted, block_address,
//                                                region_index, bytes_left
//   csr       in         csr_write_enable        csr_index, csr_write_data
//
// a transfer on req starts a scan that checks one region per cycle, until
// it finds its result, with a single shared fit unit; a reserve stops at the
// first fitting region, a restart checks no region; the result lands in an
// output register; a scan that finishes while that register is still held
// waits in place, with no state changed, until rsp frees up; req_ready stays
// low until the scan has written its result, so a new request waits for it
// synchronous active-high reset: cursors and first addresses go to 1, last
// addresses to 0, no result pending
// ----------------------------------------------------------------------------
module multi_region_bump_allocator (
   input  logic                          clock,
   input  logic                          reset,

   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_command,
   input  logic [mrba_pkg::ADDR_W-1:0]   req_request_bytes,

   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_granted,
   output logic [mrba_pkg::ADDR_W-1:0]   rsp_block_address,
   output logic [mrba_pkg::RIDX_W-1:0]   rsp_region_index,
   output logic [mrba_pkg::LEFT_W-1:0]   rsp_bytes_left,

   input  logic                          csr_write_enable,
   input  logic [mrba_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [mrba_pkg::ADDR_W-1:0]   csr_write_data
);
   import mrba_pkg::*;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(REGIONS - 1);

   // sequencer
   state_type             state_ff, state_in;
   logic [IDX_W-1:0]      scan_idx_ff, scan_idx_in;

   // captured request
   logic                  cmd_ff, cmd_in;
   logic [ADDR_W-1:0]     size_ff, size_in;

   // region registers and cursors
   logic [ADDR_W-1:0]     first_ff [MAX_REGIONS];
   logic [ADDR_W-1:0]     first_in [MAX_REGIONS];
   logic [ADDR_W-1:0]     last_ff  [MAX_REGIONS];
   logic [ADDR_W-1:0]     last_in  [MAX_REGIONS];
   logic [CURSOR_W-1:0]   cursor_ff [REGIONS];
   logic [CURSOR_W-1:0]   cursor_in [REGIONS];

   // output register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_granted_ff, rsp_granted_in;
   logic [ADDR_W-1:0]     rsp_addr_ff, rsp_addr_in;
   logic [RIDX_W-1:0]     rsp_ridx_ff, rsp_ridx_in;
   logic [LEFT_W-1:0]     rsp_left_ff, rsp_left_in;

   logic                  out_free;
   fit_type               fit;

   // shared fit unit looks at the region under the scan index
   mrba_fit_unit u_fit (
      .cursor    (cursor_ff[scan_idx_ff]),
      .last_addr (last_ff[MAX_IDX_W'(scan_idx_ff)]),
      .size      (size_ff),
      .result    (fit)
   );

   // output slot is free when empty or being drained this cycle
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in       = state_ff;
      scan_idx_in    = scan_idx_ff;
      cmd_in         = cmd_ff;
      size_in        = size_ff;
      first_in       = first_ff;
      last_in        = last_ff;
      cursor_in      = cursor_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_granted_in = rsp_granted_ff;
      rsp_addr_in    = rsp_addr_ff;
      rsp_ridx_in    = rsp_ridx_ff;
      rsp_left_in    = rsp_left_ff;

      // the user must write registers only while idle; the block does not enforce it
      if (csr_write_enable) begin
         if (csr_index[0] == CSR_SEL_LAST) begin
            last_in[csr_index[CSR_IDX_W-1:1]] = csr_write_data;
         end else begin
            first_in[csr_index[CSR_IDX_W-1:1]] = csr_write_data;
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in      = req_command;
               size_in     = req_request_bytes;
               scan_idx_in = '0;
               state_in    = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (cmd_ff == CMD_RESTART) begin
               // every cursor back to its region start, empty result
               if (out_free) begin
                  for (int i = 0; i < REGIONS; i++) begin
                     cursor_in[i] = {1'b0, first_ff[i]};
                  end
                  rsp_valid_in   = 1'b1;
                  rsp_granted_in = 1'b0;
                  rsp_addr_in    = '0;
                  rsp_ridx_in    = '0;
                  rsp_left_in    = '0;
                  state_in       = ST_IDLE;
               end
            end else if (fit.fits) begin
               // first fit: bump this cursor and report the block
               if (out_free) begin
                  cursor_in[scan_idx_ff] = fit.next_cursor;
                  rsp_valid_in   = 1'b1;
                  rsp_granted_in = 1'b1;
                  rsp_addr_in    = fit.start;
                  rsp_ridx_in    = RIDX_W'(scan_idx_ff);
                  rsp_left_in    = fit.left;
                  state_in       = ST_IDLE;
               end
            end else if (scan_idx_ff == LAST_IDX) begin
               // no region fits, nothing changes
               if (out_free) begin
                  rsp_valid_in   = 1'b1;
                  rsp_granted_in = 1'b0;
                  rsp_addr_in    = '0;
                  rsp_ridx_in    = '0;
                  rsp_left_in    = '0;
                  state_in       = ST_IDLE;
               end
            end else begin
               scan_idx_in = scan_idx_ff + IDX_W'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         scan_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < MAX_REGIONS; i++) begin
            first_ff[i] <= ADDR_W'(1);
            last_ff[i]  <= '0;
         end
         for (int i = 0; i < REGIONS; i++) begin
            cursor_ff[i] <= CURSOR_W'(1);
         end
      end else begin
         state_ff     <= state_in;
         scan_idx_ff  <= scan_idx_in;
         rsp_valid_ff <= rsp_valid_in;
         first_ff     <= first_in;
         last_ff      <= last_in;
         cursor_ff    <= cursor_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      cmd_ff         <= cmd_in;
      size_ff        <= size_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_addr_ff    <= rsp_addr_in;
      rsp_ridx_ff    <= rsp_ridx_in;
      rsp_left_ff    <= rsp_left_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_granted       = rsp_granted_ff;
   assign rsp_block_address = rsp_addr_ff;
   assign rsp_region_index  = rsp_ridx_ff;
   assign rsp_bytes_left    = rsp_left_ff;

endmodule

FILE: design/mrba_checker.sv
// ----------------------------------------------------------------------------
// mrba_checker
// port-level checks of the bump allocator, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mrba_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic                           rsp_granted,
   input logic [mrba_pkg::ADDR_W-1:0]    rsp_block_address,
   input logic [mrba_pkg::RIDX_W-1:0]    rsp_region_index,
   input logic [mrba_pkg::LEFT_W-1:0]    rsp_bytes_left
);
   import mrba_pkg::*;

   localparam logic [ADDR_W-1:0] ALIGN_LOW = ADDR_W'(ALIGN_BYTES - 1);

   logic                             fields_zero;
   logic                             addr_aligned;
   logic [ADDR_W+RIDX_W+LEFT_W:0]    rsp_payload;

   assign fields_zero  = (rsp_block_address == '0) && (rsp_region_index == '0) &&
                         (rsp_bytes_left == '0);
   assign addr_aligned = (rsp_block_address & ALIGN_LOW) == '0;
   assign rsp_payload  = {rsp_granted, rsp_block_address, rsp_region_index, rsp_bytes_left};

   // a failed reserve or a restart reports all zeros
   `ASSERT_IMPLY(a_fail_zero, clock, reset, rsp_valid && !rsp_granted, fields_zero)

   // granted blocks start on an alignment boundary
   `ASSERT_IMPLY(a_grant_aligned, clock, reset, rsp_valid && rsp_granted, addr_aligned)

   // the block is busy scanning right after taking a request
   `ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready)

   // a stalled result holds
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload))

endmodule

bind multi_region_bump_allocator mrba_checker u_mrba_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_granted       (rsp_granted),
   .rsp_block_address (rsp_block_address),
   .rsp_region_index  (rsp_region_index),
   .rsp_bytes_left    (rsp_bytes_left)
);
